>>> rtl/core/ktbl_pkg.sv
// Shared types, codes and controller/datapath bundles for the keyed table.
`timescale 1ns / 1ps
`default_nettype none

package ktbl_pkg;

	localparam int ECNT_W = 5;
	localparam int CFG_AW = 3;

	typedef logic [1:0]        op_t;
	typedef logic [15:0]       key_t;
	typedef logic [31:0]       pay_t;
	typedef logic [1:0]        st_t;
	typedef logic [ECNT_W-1:0] ecnt_t;
	typedef logic [31:0]       cfg_data_t;
	typedef logic [CFG_AW-1:0] cfg_addr_t;

	// Request operations
	localparam op_t OP_ADD = 2'd0;
	localparam op_t OP_DEL = 2'd1;
	localparam op_t OP_GET = 2'd2;
	localparam op_t OP_UPD = 2'd3;

	// Response status codes
	localparam st_t ST_OK      = 2'd0;
	localparam st_t ST_FULL    = 2'd1;
	localparam st_t ST_DUP     = 2'd2;
	localparam st_t ST_MISSING = 2'd3;

	// Register index (word address bits above the byte offset)
	localparam logic [CFG_AW-3:0] REG_MAX_ENTRIES = '0;
	localparam ecnt_t             MAX_ENTRIES_RST = 5'd16;

	// Controller to datapath commands
	typedef struct packed {
		logic start;
		logic scan_rd;
		logic decide;
		logic append;
		logic update;
		logic shift_init;
		logic shift_rd;
		logic drop;
		logic respond;
	} ktbl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic at_end;
		logic out_free;
		op_t  op;
		st_t  st_now;
	} ktbl_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/ktbl_if.sv
// Request and response channel interfaces for the keyed table.
`timescale 1ns / 1ps
`default_nettype none

interface ktbl_req_if;
	import ktbl_pkg::*;

	logic valid;
	logic ready;
	op_t  operation;
	key_t key;
	key_t new_key;
	pay_t payload;

	modport source (output valid, output operation, output key, output new_key,
		output payload, input ready);
	modport sink (input valid, input operation, input key, input new_key,
		input payload, output ready);
endinterface

interface ktbl_rsp_if;
	import ktbl_pkg::*;

	logic  valid;
	logic  ready;
	st_t   status;
	pay_t  payload_out;
	ecnt_t entry_count;

	modport source (output valid, output status, output payload_out,
		output entry_count, input ready);
	modport sink (input valid, input status, input payload_out,
		input entry_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ktbl_cfg.sv
// APB register block holding the max_entries capacity register.
`timescale 1ns / 1ps
`default_nettype none

module ktbl_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  ktbl_pkg::cfg_addr_t paddr,
	input  ktbl_pkg::cfg_data_t pwdata,
	output ktbl_pkg::cfg_data_t prdata,
	output logic                pready,
	output ktbl_pkg::ecnt_t     max_entries
);
	import ktbl_pkg::*;

	ecnt_t max_entries_q;
	logic  sel_max;

	// Decode the word index, ignore the byte offset
	assign sel_max = (paddr[CFG_AW-1:2] == REG_MAX_ENTRIES);
	assign pready  = 1'b1;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
		end else if (psel && penable && pwrite && sel_max) begin
			max_entries_q <= pwdata[ECNT_W-1:0];
		end
	end

	assign prdata      = sel_max ? cfg_data_t'(max_entries_q) : '0;
	assign max_entries = max_entries_q;

endmodule

`default_nettype wire

>>> rtl/core/ktbl_ctrl.sv
// Sequencer for scan, decide, shift and respond phases of each request.
`timescale 1ns / 1ps
`default_nettype none

module ktbl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ktbl_pkg::ktbl_stat_t stat,
	output ktbl_pkg::ktbl_cmd_t  cmd
);
	import ktbl_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_RESP   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       ok_now;

	assign in_ready = (state_q == S_IDLE);
	assign ok_now   = (stat.st_now == ST_OK);

	// Next state and command decode
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.at_end) begin
					state_d = S_DECIDE;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			S_DECIDE: begin
				cmd.decide     = 1'b1;
				cmd.append     = ok_now && (stat.op == OP_ADD);
				cmd.update     = ok_now && (stat.op == OP_UPD);
				cmd.shift_init = ok_now && (stat.op == OP_DEL);
				state_d        = (ok_now && (stat.op == OP_DEL)) ? S_SHIFT : S_RESP;
			end
			S_SHIFT: begin
				if (stat.at_end) begin
					cmd.drop = 1'b1;
					state_d  = S_RESP;
				end else begin
					cmd.shift_rd = 1'b1;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.respond = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ktbl_dp.sv
// Datapath: entry memories, scan compare, shift mover, count and response register.
`timescale 1ns / 1ps
`default_nettype none

module ktbl_dp #(
	parameter int DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ktbl_pkg::op_t        operation,
	input  ktbl_pkg::key_t       key,
	input  ktbl_pkg::key_t       new_key,
	input  ktbl_pkg::pay_t       payload,
	input  ktbl_pkg::ecnt_t      max_entries,
	input  ktbl_pkg::ktbl_cmd_t  cmd,
	output ktbl_pkg::ktbl_stat_t stat,
	ktbl_rsp_if.source           rsp
);
	import ktbl_pkg::*;

	localparam int IW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > ECNT_W) ? CW : ECNT_W;

	// Entry storage
	key_t key_mem [DEPTH];
	pay_t pay_mem [DEPTH];

	// Latched request
	op_t  op_q;
	key_t key_q;
	key_t nkey_q;
	pay_t pay_in_q;

	// Scan and shift control
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          cmp_s1;
	logic          mv_s1;
	logic [IW-1:0] addr_s1;
	key_t          rkey_s1;
	pay_t          rpay_s1;
	logic          rd_en;

	// Search results
	logic          found_k_q;
	logic          found_n_q;
	logic [IW-1:0] pos_k_q;
	logic [IW-1:0] pos_n_q;
	pay_t          hit_pay_q;
	st_t           st_q;
	st_t           st_now;
	logic          full;
	logic          hit_k;
	logic          hit_n;

	// Response register
	logic            out_valid_q;
	st_t             out_st_q;
	pay_t            out_pay_q;
	ecnt_t           out_cnt_q;
	logic [CMPW-1:0] cnt_ext;

	// Write port
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	key_t          wr_key;
	pay_t          wr_pay;

	assign rd_en   = cmd.scan_rd | cmd.shift_rd;
	assign hit_k   = cmp_s1 && !found_k_q && (rkey_s1 == key_q);
	assign hit_n   = cmp_s1 && !found_n_q && (rkey_s1 == nkey_q);
	assign cnt_ext = CMPW'(count_q);

	// Capacity is max_entries limited to DEPTH
	assign full = (cnt_ext >= CMPW'(max_entries)) || (count_q == CW'(DEPTH));

	// Outcome of the request from the scan results
	always_comb begin
		st_now = ST_OK;
		unique case (op_q)
			OP_ADD: begin
				if (full) begin
					st_now = ST_FULL;
				end else if (found_k_q) begin
					st_now = ST_DUP;
				end
			end
			OP_DEL, OP_GET: begin
				if (!found_k_q) begin
					st_now = ST_MISSING;
				end
			end
			OP_UPD: begin
				if (found_n_q && (!found_k_q || (pos_n_q != pos_k_q))) begin
					st_now = ST_DUP;
				end else if (!found_k_q) begin
					st_now = ST_MISSING;
				end
			end
			default: begin
				st_now = ST_OK;
			end
		endcase
	end

	// Select the single write: append, in-place update or shift move
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IW-1:0];
		wr_key  = key_q;
		wr_pay  = pay_in_q;
		priority if (cmd.append) begin
			wr_en = 1'b1;
		end else if (cmd.update) begin
			wr_en   = 1'b1;
			wr_addr = pos_k_q;
			wr_key  = nkey_q;
		end else if (mv_s1) begin
			wr_en   = 1'b1;
			wr_addr = addr_s1 - 1'b1;
			wr_key  = rkey_s1;
			wr_pay  = rpay_s1;
		end else begin
			// hold the memories
			wr_en = 1'b0;
		end
	end

	// Entry memories, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			pay_mem[wr_addr] <= wr_pay;
		end
		if (rd_en) begin
			rkey_s1 <= key_mem[idx_q[IW-1:0]];
			rpay_s1 <= pay_mem[idx_q[IW-1:0]];
			addr_s1 <= idx_q[IW-1:0];
		end
	end

	// Control state: index, count, hit flags, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			count_q     <= '0;
			cmp_s1      <= 1'b0;
			mv_s1       <= 1'b0;
			found_k_q   <= 1'b0;
			found_n_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_s1 <= cmd.scan_rd;
			mv_s1  <= cmd.shift_rd;

			if (cmd.start) begin
				idx_q <= '0;
			end else if (cmd.shift_init) begin
				idx_q <= CW'(pos_k_q) + 1'b1;
			end else if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end

			if (cmd.start) begin
				found_k_q <= 1'b0;
				found_n_q <= 1'b0;
			end else begin
				if (hit_k) begin
					found_k_q <= 1'b1;
				end
				if (hit_n) begin
					found_n_q <= 1'b1;
				end
			end

			if (cmd.append) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.drop) begin
				count_q <= count_q - 1'b1;
			end

			if (cmd.respond) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q     <= operation;
			key_q    <= key;
			nkey_q   <= new_key;
			pay_in_q <= payload;
		end
		if (hit_k) begin
			pos_k_q   <= addr_s1;
			hit_pay_q <= rpay_s1;
		end
		if (hit_n) begin
			pos_n_q <= addr_s1;
		end
		if (cmd.decide) begin
			st_q <= st_now;
		end
		if (cmd.respond) begin
			out_st_q  <= st_q;
			out_pay_q <= ((op_q == OP_GET) && (st_q == ST_OK)) ? hit_pay_q : '0;
			out_cnt_q <= cnt_ext[ECNT_W-1:0];
		end
	end

	assign stat.at_end   = (idx_q == count_q);
	assign stat.out_free = !out_valid_q || rsp.ready;
	assign stat.op       = op_q;
	assign stat.st_now   = st_now;

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_st_q;
	assign rsp.payload_out = out_pay_q;
	assign rsp.entry_count = out_cnt_q;

endmodule

`default_nettype wire

>>> rtl/core/keyed_table_insert_delete_lookup.sv
// Each request scans the held entries, decides, shifts the later entries down for a delete,
// and then responds; one request is in flight at a time.
// The rate is set by the single read port of the entry memory, one entry per cycle for the
// key scan and again for the delete compaction. A finished response waits in its own register.
// Reset (arst_n low, asynchronous) empties the table and sets max_entries to 16;
// entry memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module keyed_table_insert_delete_lookup #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	ktbl_req_if.sink            req,
	ktbl_rsp_if.source          rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  ktbl_pkg::cfg_addr_t paddr,
	input  ktbl_pkg::cfg_data_t pwdata,
	output ktbl_pkg::cfg_data_t prdata,
	output logic                pready
);
	import ktbl_pkg::*;

	ecnt_t      max_entries;
	ktbl_cmd_t  cmd;
	ktbl_stat_t stat;

	// Capacity register
	ktbl_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.max_entries (max_entries)
	);

	// Request sequencer
	ktbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Table storage and search
	ktbl_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.operation   (req.operation),
		.key         (req.key),
		.new_key     (req.new_key),
		.payload     (req.payload),
		.max_entries (max_entries),
		.cmd         (cmd),
		.stat        (stat),
		.rsp         (rsp)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_keyed_table_insert_delete_lookup.sv
// Self-checking testbench for the keyed table: request driver, response monitor, table predictor.
`timescale 1ns / 1ps

module tb_keyed_table_insert_delete_lookup;
	import ktbl_pkg::*;

	localparam int TBL_DEPTH      = 16;
	localparam int PHASE_ITEMS    = 175;
	localparam int N_PHASES       = 8;
	localparam int KEY_POOL_SIZE  = 24;
	localparam int DRAIN_CYCLES   = 2 * TBL_DEPTH + 8;
	localparam int CYCLE_LIMIT    = 600000;
	localparam cfg_addr_t MAX_ENTRIES_ADDR = {REG_MAX_ENTRIES, 2'b00};

	typedef struct packed {
		op_t  op;
		key_t key;
		key_t new_key;
		pay_t payload;
	} req_beat_t;

	typedef struct packed {
		st_t   status;
		pay_t  payload_out;
		ecnt_t entry_count;
	} rsp_beat_t;

	logic      clk     = 1'b0;
	logic      arst_n  = 1'b0;
	logic      psel    = 1'b0;
	logic      penable = 1'b0;
	logic      pwrite  = 1'b0;
	cfg_addr_t paddr   = '0;
	cfg_data_t pwdata  = '0;
	cfg_data_t prdata;
	logic      pready;

	ktbl_req_if req_if();
	ktbl_rsp_if rsp_if();

	logic      req_valid = 1'b0;
	req_beat_t req_drv   = '0;
	logic      rsp_ready = 1'b0;

	assign req_if.valid     = req_valid;
	assign req_if.operation = req_drv.op;
	assign req_if.key       = req_drv.key;
	assign req_if.new_key   = req_drv.new_key;
	assign req_if.payload   = req_drv.payload;
	assign rsp_if.ready     = rsp_ready;

	keyed_table_insert_delete_lookup #(
		.DEPTH(TBL_DEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Table mirror and bookkeeping
	key_t        tbl_key [TBL_DEPTH];
	pay_t        tbl_pay [TBL_DEPTH];
	int          tbl_cnt = 0;
	int          tbl_cap = MAX_ENTRIES_RST;
	key_t        key_pool [KEY_POOL_SIZE];
	req_beat_t   request_q [$];
	rsp_beat_t   answer_q [$];
	int unsigned req_sent = 0;
	int unsigned req_taken = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          err_cnt = 0;
	int          n_checked = 0;
	int          n_full = 0;
	int          n_dup = 0;
	int          n_missing = 0;
	int          n_settings = 0;
	int          cycles = 0;

	// Position of a key among the held entries, TBL_DEPTH when absent
	function automatic int tbl_find(key_t k);
		for (int i = 0; i < tbl_cnt; i++) begin
			if (tbl_key[i] == k) begin
				return i;
			end
		end
		return TBL_DEPTH;
	endfunction

	// Apply one request to the mirror and return the answer it must produce
	function automatic rsp_beat_t tbl_apply(req_beat_t r);
		rsp_beat_t a;
		int pos;
		int other;
		int eff_cap;
		a = '0;
		a.status = ST_OK;
		eff_cap = (tbl_cap > TBL_DEPTH) ? TBL_DEPTH : tbl_cap;
		case (r.op)
			OP_ADD: begin
				if (tbl_cnt >= eff_cap) begin
					a.status = ST_FULL;
				end else if (tbl_find(r.key) != TBL_DEPTH) begin
					a.status = ST_DUP;
				end else begin
					tbl_key[tbl_cnt] = r.key;
					tbl_pay[tbl_cnt] = r.payload;
					tbl_cnt++;
				end
			end
			OP_DEL: begin
				pos = tbl_find(r.key);
				if (pos == TBL_DEPTH) begin
					a.status = ST_MISSING;
				end else begin
					// close the gap left by the removed entry
					for (int j = pos; j + 1 < tbl_cnt; j++) begin
						tbl_key[j] = tbl_key[j + 1];
						tbl_pay[j] = tbl_pay[j + 1];
					end
					tbl_cnt--;
				end
			end
			OP_GET: begin
				pos = tbl_find(r.key);
				if (pos == TBL_DEPTH) begin
					a.status = ST_MISSING;
				end else begin
					a.payload_out = tbl_pay[pos];
				end
			end
			default: begin
				pos = tbl_find(r.key);
				other = tbl_find(r.new_key);
				if (other != TBL_DEPTH && other != pos) begin
					a.status = ST_DUP;
				end else if (pos == TBL_DEPTH) begin
					a.status = ST_MISSING;
				end else begin
					tbl_key[pos] = r.new_key;
					tbl_pay[pos] = r.payload;
				end
			end
		endcase
		a.entry_count = ecnt_t'(tbl_cnt);
		return a;
	endfunction

	task automatic push_req(input op_t op, input key_t k, input key_t nk, input pay_t pl);
		req_beat_t r;
		r.op      = op;
		r.key     = k;
		r.new_key = nk;
		r.payload = pl;
		request_q.push_back(r);
	endtask

	// Hold until every queued request is sent, accepted and answered
	task automatic wait_table_idle();
		while (request_q.size() != 0 || req_sent != req_taken || answer_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// APB setup and access phases; only called with the table idle
	task automatic write_max_entries(input int value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MAX_ENTRIES_ADDR;
		pwdata  <= cfg_data_t'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tbl_cap = value & 5'h1F;
		n_settings++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_keyed_table_insert_delete_lookup: errors");
			$finish;
		end
	end

	// Request driver and response back-pressure, both on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_sent != req_taken) begin
			// hold the beat until it is taken
		end else if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			req_drv   <= request_q.pop_front();
			req_valid <= 1'b1;
			req_sent  <= req_sent + 1;
		end else begin
			req_valid <= 1'b0;
		end
		rsp_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: check answers first, then predict for a newly taken request
	always @(posedge clk) begin
		rsp_beat_t want;
		req_beat_t got_req;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (answer_q.size() == 0) begin
					$error("response beat with no request outstanding");
					err_cnt++;
				end else begin
					want = answer_q.pop_front();
					n_checked++;
					if (rsp_if.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_if.status);
						err_cnt++;
					end
					if (rsp_if.payload_out !== want.payload_out) begin
						$error("payload_out: expected %h, got %h",
							want.payload_out, rsp_if.payload_out);
						err_cnt++;
					end
					if (rsp_if.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, rsp_if.entry_count);
						err_cnt++;
					end
					case (want.status)
						ST_FULL:    n_full++;
						ST_DUP:     n_dup++;
						ST_MISSING: n_missing++;
						default:    ;
					endcase
				end
			end
			if (req_if.valid && req_if.ready) begin
				got_req.op      = req_if.operation;
				got_req.key     = req_if.key;
				got_req.new_key = req_if.new_key;
				got_req.payload = req_if.payload;
				answer_q.push_back(tbl_apply(got_req));
				req_taken <= req_taken + 1;
			end
		end
	end

	// Stimulus sequence
	initial begin
		int cap_plan [N_PHASES];
		int r;
		op_t op;
		key_t k;
		key_t nk;
		cap_plan = '{31, 1, 16, 3, 0, 20, 8, 16};
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;
		for (int i = 2; i < KEY_POOL_SIZE; i++) begin
			key_pool[i] = key_t'($urandom);
		end

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Empty table, then extreme keys and payloads, duplicates and updates
		push_req(OP_GET, 16'h0000, 16'h0000, 32'h0);
		push_req(OP_DEL, 16'h0000, 16'h0000, 32'h0);
		push_req(OP_UPD, 16'h0001, 16'h0002, 32'h1);
		push_req(OP_ADD, 16'h0000, 16'hFFFF, 32'h0000_0000);
		push_req(OP_ADD, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
		push_req(OP_ADD, 16'h0000, 16'h0000, 32'h1111_1111);
		push_req(OP_GET, 16'hFFFF, 16'h0000, 32'h0);
		// same key: payload replaced
		push_req(OP_UPD, 16'hFFFF, 16'hFFFF, 32'hA5A5_5A5A);
		// new key held by another entry
		push_req(OP_UPD, 16'h0000, 16'hFFFF, 32'h2222_2222);
		// duplicate wins even when the key itself is absent
		push_req(OP_UPD, 16'h0005, 16'hFFFF, 32'h3333_3333);
		push_req(OP_UPD, 16'h0000, 16'h1234, 32'h1234_5678);
		push_req(OP_ADD, 16'h0007, 16'h0000, 32'h7777_0007);
		// delete at the head forces a full shift
		push_req(OP_DEL, 16'h1234, 16'h0000, 32'h0);
		push_req(OP_GET, 16'h0007, 16'h0000, 32'h0);
		push_req(OP_GET, 16'hFFFF, 16'h0000, 32'h0);
		push_req(OP_ADD, 16'hAAAA, 16'h5555, $urandom);
		wait_table_idle();

		// Capacity lowered below the count; full is checked before duplicate
		write_max_entries(2);
		push_req(OP_ADD, 16'h0007, 16'h0000, 32'h0);
		push_req(OP_ADD, 16'h0003, 16'h0000, 32'h0);
		push_req(OP_DEL, 16'hFFFF, 16'h0000, 32'h0);
		push_req(OP_ADD, 16'h0003, 16'h0000, 32'h0);
		wait_table_idle();

		// Capacity zero
		write_max_entries(0);
		push_req(OP_ADD, 16'h0009, 16'h0000, 32'h9);
		push_req(OP_GET, 16'h0007, 16'h0000, 32'h0);
		wait_table_idle();

		// Random phases: each sets a capacity and one of four pacing modes
		for (int p = 0; p < N_PHASES; p++) begin
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 52;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 52;
				end
				default: begin
					send_idle_pct = 19;
					recv_stall_pct = 19;
				end
			endcase
			write_max_entries(cap_plan[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(99);
				op = (r < 40) ? OP_ADD : (r < 60) ? OP_DEL : (r < 80) ? OP_GET : OP_UPD;
				// mostly pooled keys so hits and duplicates are common
				if ($urandom_range(99) < 85) begin
					k = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
				end else begin
					k = key_t'($urandom);
				end
				r = $urandom_range(99);
				if (r < 30) begin
					nk = k;
				end else if (r < 85) begin
					nk = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
				end else begin
					nk = key_t'($urandom);
				end
				push_req(op, k, nk, pay_t'($urandom));
			end
			wait_table_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d answers over %0d capacity settings and four pacing modes.",
			n_checked, n_settings);
		$display("Answers seen: %0d table full, %0d duplicate key, %0d key not found.",
			n_full, n_dup, n_missing);
		if (err_cnt == 0 && answer_q.size() == 0) begin
			$display("tb_keyed_table_insert_delete_lookup: clean");
		end else begin
			$display("tb_keyed_table_insert_delete_lookup: errors");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/ktbl_pkg.sv
rtl/core/ktbl_if.sv
rtl/core/ktbl_cfg.sv
rtl/core/ktbl_ctrl.sv
rtl/core/ktbl_dp.sv
rtl/core/keyed_table_insert_delete_lookup.sv
tb/sv/tb_keyed_table_insert_delete_lookup.sv
